// ===== rtl/core/vwir_pkg.sv =====
// Package with types, constants and codes for the vertex weld index remap block.
`default_nettype none
package vwir_pkg;
    localparam int TableDepth = 1024;
    localparam int LocalDepth = 256;
    localparam int CompBits = 24;
    localparam int IdxBits = $clog2(TableDepth);
    localparam int CntBits = IdxBits + 1;
    localparam int LocBits = 8;
    localparam int RemapDepth = 2 * 3 * LocalDepth;
    localparam int RemapAddrBits = $clog2(RemapDepth);
    localparam int VecBits = 3 * CompBits;
    localparam int ThreshBits = 52;
    localparam int QueueDepth = 2;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_MAP = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] ATTR_POS = 2'd0;
    localparam logic [1:0] ATTR_NRM = 2'd1;
    localparam logic [1:0] ATTR_UV = 2'd2;
    localparam logic [1:0] ATTR_NONE = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] attribute;
        logic cluster;
        logic [LocBits-1:0] local_index;
        logic signed [CompBits-1:0] comp_a;
        logic signed [CompBits-1:0] comp_b;
        logic signed [CompBits-1:0] comp_c;
    } in_item_t;

    typedef struct packed {
        logic [IdxBits-1:0] merged_index;
        logic added;
        logic error;
    } out_item_t;

    // Classified work handed from the front part to the back part.
    typedef struct packed {
        logic do_add;
        logic do_map;
        logic do_clear;
        logic [1:0] attribute;
        logic loc_ok;
        logic [RemapAddrBits-1:0] remap_addr;
        logic [VecBits-1:0] vec;
    } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/vwir_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module vwir_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/vwir_front.sv =====
// Front part: accepts items, classifies them and places commands in a short queue.
`default_nettype none
module vwir_front
    import vwir_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);
    localparam int PtrBits = $clog2(QueueDepth);

    cmd_t q_reg [QueueDepth];
    logic [PtrBits-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PtrBits:0] cnt_reg, cnt_next;
    cmd_t c;
    logic push, pop;

    always_comb begin
        c = '0;
        c.attribute = s_data.attribute;
        c.loc_ok = ({1'b0, s_data.local_index} < (LocBits+1)'(LocalDepth));
        c.do_clear = (s_data.kind == KIND_CLEAR);
        c.do_add = (s_data.kind == KIND_ADD) && (s_data.attribute != ATTR_NONE);
        c.do_map = (s_data.kind == KIND_MAP) && (s_data.attribute != ATTR_NONE) && c.loc_ok;
        c.remap_addr = RemapAddrBits'((({1'b0, s_data.cluster} * 3 + s_data.attribute)
                       * LocalDepth) + s_data.local_index);
        c.vec = {s_data.comp_a, s_data.comp_b,
                 (s_data.attribute == ATTR_UV) ? CompBits'(0) : s_data.comp_c};
    end

    assign s_ready = (cnt_reg != (PtrBits+1)'(QueueDepth));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd = q_reg[rp_reg];
    assign push = s_valid && s_ready;
    assign pop = cmd_valid && cmd_ready;

    always_comb begin
        wp_next = push ? PtrBits'(wp_reg + 1'b1) : wp_reg;
        rp_next = pop ? PtrBits'(rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            q_reg[wp_reg] <= c;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/vwir_back.sv =====
// Back part: scans the merged tables, appends new entries and serves the remap store.
`default_nettype none
module vwir_back
    import vwir_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [ThreshBits-1:0] threshold,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire cmd_t                  cmd,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_MAPW = 3'd4;
    localparam logic [2:0] ST_MAPR = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam int SqBits = 2 * (CompBits + 1);
    localparam int DistBits = SqBits + 2;

    logic [2:0] st_reg, st_next;
    cmd_t cmd_reg;
    logic [CntBits-1:0] cnt_reg [3];
    logic [CntBits-1:0] i_reg, i_next, n_cur;
    out_item_t res_reg, res_next;
    logic [SqBits-1:0] sq_reg [3];
    logic [DistBits-1:0] sq_sum;
    logic signed [CompBits:0] diff [3];

    logic [VecBits-1:0] rd_pos, rd_nrm, rd_uv, rd_vec;
    logic [IdxBits-1:0] remap_rd;
    logic [IdxBits-1:0] tbl_raddr;
    logic wr_tbl, wr_remap;
    logic [IdxBits-1:0] wr_tbl_addr, wr_remap_data;

    assign n_cur = cnt_reg[cmd_reg.attribute];
    assign tbl_raddr = (st_reg == ST_IDLE) ? '0 : IdxBits'(i_next);

    vwir_ram #(.Width(VecBits), .Depth(TableDepth)) u_pos (
        .aclk(aclk), .wr_en(wr_tbl && cmd_reg.attribute == ATTR_POS),
        .wr_addr(wr_tbl_addr), .wr_data(cmd_reg.vec),
        .rd_addr(tbl_raddr), .rd_data(rd_pos));
    vwir_ram #(.Width(VecBits), .Depth(TableDepth)) u_nrm (
        .aclk(aclk), .wr_en(wr_tbl && cmd_reg.attribute == ATTR_NRM),
        .wr_addr(wr_tbl_addr), .wr_data(cmd_reg.vec),
        .rd_addr(tbl_raddr), .rd_data(rd_nrm));
    vwir_ram #(.Width(VecBits), .Depth(TableDepth)) u_uv (
        .aclk(aclk), .wr_en(wr_tbl && cmd_reg.attribute == ATTR_UV),
        .wr_addr(wr_tbl_addr), .wr_data(cmd_reg.vec),
        .rd_addr(tbl_raddr), .rd_data(rd_uv));
    vwir_ram #(.Width(IdxBits), .Depth(RemapDepth)) u_remap (
        .aclk(aclk), .wr_en(wr_remap), .wr_addr(cmd_reg.remap_addr),
        .wr_data(wr_remap_data), .rd_addr(cmd_reg.remap_addr), .rd_data(remap_rd));

    always_comb begin
        case (cmd_reg.attribute)
            ATTR_POS: rd_vec = rd_pos;
            ATTR_NRM: rd_vec = rd_nrm;
            default:  rd_vec = rd_uv;
        endcase
        for (int k = 0; k < 3; k++) begin
            diff[k] = (CompBits+1)'($signed(cmd_reg.vec[(2-k)*CompBits +: CompBits]))
                    - (CompBits+1)'($signed(rd_vec[(2-k)*CompBits +: CompBits]));
        end
        sq_sum = DistBits'(sq_reg[0]) + DistBits'(sq_reg[1]) + DistBits'(sq_reg[2]);
    end

    always_comb begin
        st_next = st_reg;
        i_next = i_reg;
        res_next = res_reg;
        wr_tbl = 1'b0;
        wr_remap = 1'b0;
        wr_tbl_addr = IdxBits'(n_cur);
        wr_remap_data = res_reg.merged_index;
        cmd_ready = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                i_next = '0;
                if (cmd_valid) begin
                    res_next = '0;
                    if (cmd.do_add) begin
                        st_next = ST_SCAN;
                    end else if (cmd.do_map) begin
                        st_next = ST_MAPW;
                    end else begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                // Read data for entry i is valid here.
                if (i_reg >= n_cur) begin
                    if (n_cur[CntBits-1]) begin
                        res_next.error = 1'b1;
                        st_next = ST_OUT;
                    end else begin
                        wr_tbl = 1'b1;
                        res_next.merged_index = IdxBits'(n_cur);
                        res_next.added = 1'b1;
                        wr_remap = cmd_reg.loc_ok;
                        wr_remap_data = IdxBits'(n_cur);
                        st_next = ST_OUT;
                    end
                end else begin
                    st_next = ST_SQ;
                end
            end
            ST_SQ: st_next = ST_SUM;
            ST_SUM: begin
                if (sq_sum <= DistBits'(threshold)) begin
                    res_next.merged_index = IdxBits'(i_reg);
                    wr_remap = cmd_reg.loc_ok;
                    wr_remap_data = IdxBits'(i_reg);
                    st_next = ST_OUT;
                end else begin
                    i_next = i_reg + 1'b1;
                    st_next = ST_SCAN;
                end
            end
            ST_MAPW: st_next = ST_MAPR;
            ST_MAPR: begin
                res_next.merged_index = remap_rd;
                st_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    assign m_valid = (st_reg == ST_OUT);
    assign m_data = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            for (int k = 0; k < 3; k++) cnt_reg[k] <= '0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_IDLE && cmd_valid && cmd.do_clear) begin
                for (int k = 0; k < 3; k++) cnt_reg[k] <= '0;
            end else if (wr_tbl) begin
                cnt_reg[cmd_reg.attribute] <= n_cur + 1'b1;
            end
        end
        i_reg <= i_next;
        res_reg <= res_next;
        if (st_reg == ST_IDLE && cmd_valid) begin
            cmd_reg <= cmd;
        end
        for (int k = 0; k < 3; k++) begin
            sq_reg[k] <= SqBits'(diff[k] * diff[k]);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/vertex_weld_index_remap.sv =====
// Top level of the vertex weld index remap block.
// Welds attribute vectors into three merged tables and remembers where each
// cluster slot landed.
// Input channel s_*: one item per transfer; kind add, map, clear or none.
// Result channel m_*: exactly one result transfer per accepted item, in order.
// Config channel cfg_*: writes the match threshold; the user must write it only
// while the block is idle, as the block itself does not enforce this. A
// two-entry command queue lets the front accept items while the back works.
// An add scans the merged table of its attribute entry by entry through the
// table memory read and the difference, square and sum stages; it stops at the
// first entry whose squared distance is at most the threshold, or after all
// stored entries appends the vector, or fails if the table holds 1024. A map
// reads the remap store; a clear resets the table counts. The back takes the
// next command in the cycle after a result transfer. Reset clears the table
// counts, the queue and the threshold; tables and the remap store hold
// whatever they held until written. When the receiver stalls, the result holds
// on m_* and the queue fills, after which s_ready drops.
`default_nettype none
module vertex_weld_index_remap
    import vwir_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [ThreshBits-1:0] cfg_data
);
    logic [ThreshBits-1:0] thresh_reg;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= '0;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    vwir_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

    vwir_back u_back (
        .aclk(aclk), .aresetn(aresetn), .threshold(thresh_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
endmodule
`default_nettype wire

// ===== rtl/core/vwir_checker.sv =====
// Port-level checker for the vertex weld index remap block, with its bind.
`default_nettype none
module vwir_checker
    import vwir_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_add_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.added && m_data.error))
        else $error("added and error both set");
    a_err_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.merged_index == '0)
        else $error("error result with nonzero index");
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");
endmodule

bind vertex_weld_index_remap vwir_checker u_vwir_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
`default_nettype wire

// ===== test/vertex_weld_index_remap_tb.sv =====
// Testbench for the vertex weld index remap block: predicts and checks every result.
`default_nettype none
module vertex_weld_index_remap_tb;
    import vwir_pkg::*;

    localparam logic [1:0] KIND_IDLE_CODE = KIND_NONE;
    localparam logic [1:0] ATTR_IDLE_CODE = ATTR_NONE;
    localparam logic [ThreshBits-1:0] THRESH_MAX = {ThreshBits{1'b1}};
    localparam int DRAIN_CYCLES = 3 * TableDepth + 64;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [ThreshBits-1:0] cfg_data;

    vertex_weld_index_remap dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // Predicted state of the block.
    logic signed [CompBits-1:0] weld_vec[3][TableDepth][3];
    int unsigned weld_count[3];
    logic [IdxBits-1:0] slot_index[2][3][LocalDepth];
    bit slot_written[2][3][LocalDepth];
    int slot_keys[$];
    logic [ThreshBits-1:0] weld_threshold;

    out_item_t pending_results[$];
    bit failed;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #400000000;
        $display("FAIL");
        $finish;
    end

    function automatic longint unsigned sq_dist(logic signed [CompBits-1:0] a,
                                                logic signed [CompBits-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return longint'(unsigned'(d)) * longint'(unsigned'(d));
    endfunction

    function automatic out_item_t weld_predict(in_item_t it);
        out_item_t r;
        logic signed [CompBits-1:0] v[3];
        int unsigned n;
        int unsigned i;
        bit hit;
        longint unsigned d;
        r = '0;
        hit = 1'b0;
        if (it.kind == KIND_CLEAR) begin
            weld_count = '{0, 0, 0};
        end else if (it.kind == KIND_MAP && it.attribute != ATTR_IDLE_CODE) begin
            r.merged_index = slot_index[it.cluster][it.attribute][it.local_index];
        end else if (it.kind == KIND_ADD && it.attribute != ATTR_IDLE_CODE) begin
            v[0] = it.comp_a;
            v[1] = it.comp_b;
            v[2] = (it.attribute == ATTR_UV) ? '0 : it.comp_c;
            n = weld_count[it.attribute];
            for (i = 0; i < n; i++) begin
                d = sq_dist(v[0], weld_vec[it.attribute][i][0])
                    + sq_dist(v[1], weld_vec[it.attribute][i][1])
                    + sq_dist(v[2], weld_vec[it.attribute][i][2]);
                if (d <= longint'(weld_threshold)) begin
                    hit = 1'b1;
                    break;
                end
            end
            if (hit) begin
                r.merged_index = IdxBits'(i);
            end else if (n < TableDepth) begin
                weld_vec[it.attribute][n] = v;
                weld_count[it.attribute] = n + 1;
                r.merged_index = IdxBits'(n);
                r.added = 1'b1;
                hit = 1'b1;
            end else begin
                r.error = 1'b1;
            end
            if (hit) begin
                slot_index[it.cluster][it.attribute][it.local_index] = r.merged_index;
                if (!slot_written[it.cluster][it.attribute][it.local_index])
                    slot_keys = {slot_keys,
                                 int'({it.cluster, it.attribute, it.local_index})};
                slot_written[it.cluster][it.attribute][it.local_index] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic in_item_t make_item(logic [1:0] kind, logic [1:0] attr, logic clus,
                                           logic [7:0] loc, logic [23:0] a,
                                           logic [23:0] b, logic [23:0] c);
        in_item_t it;
        it.kind = kind;
        it.attribute = attr;
        it.cluster = clus;
        it.local_index = loc;
        it.comp_a = a;
        it.comp_b = b;
        it.comp_c = c;
        return it;
    endfunction

    // Valid stays high between back-to-back items; only idle cycles lower it.
    task automatic send_item(in_item_t it);
        out_item_t want;
        @(negedge aclk);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        want = weld_predict(it);
        pending_results = {pending_results, want};
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [ThreshBits-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        weld_threshold = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial begin
        out_item_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected: %p", m_data);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.merged_index !== want.merged_index) begin
                        $error("merged_index expected %0d actual %0d",
                               want.merged_index, m_data.merged_index);
                        failed = 1'b1;
                    end
                    if (m_data.added !== want.added) begin
                        $error("added expected %0d actual %0d", want.added, m_data.added);
                        failed = 1'b1;
                    end
                    if (m_data.error !== want.error) begin
                        $error("error expected %0d actual %0d", want.error, m_data.error);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_threshold('0);
        send_item(make_item(KIND_ADD, ATTR_POS, 1'b0, 8'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        send_item(make_item(KIND_ADD, ATTR_POS, 1'b0, 8'd1, 24'h800000, 24'h800000, 24'h800000));
        send_item(make_item(KIND_ADD, ATTR_POS, 1'b1, 8'd255, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        send_item(make_item(KIND_ADD, ATTR_NRM, 1'b1, 8'd128, 24'h0, 24'h0, 24'h0));
        send_item(make_item(KIND_ADD, ATTR_NRM, 1'b0, 8'd85, 24'h0, 24'h0, 24'h1));
        // The third component must not matter for texture coordinates.
        send_item(make_item(KIND_ADD, ATTR_UV, 1'b0, 8'd170, 24'h1, 24'h2, 24'h7FFFFF));
        send_item(make_item(KIND_ADD, ATTR_UV, 1'b1, 8'd170, 24'h1, 24'h2, 24'h800000));
        send_item(make_item(KIND_MAP, ATTR_POS, 1'b1, 8'd255, 24'h0, 24'h0, 24'h0));
        send_item(make_item(KIND_MAP, ATTR_POS, 1'b0, 8'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_item(make_item(KIND_MAP, ATTR_NRM, 1'b0, 8'd85, 24'h0, 24'h0, 24'h0));
        send_item(make_item(KIND_ADD, ATTR_IDLE_CODE, 1'b1, 8'd7, 24'h5, 24'h5, 24'h5));
        send_item(make_item(KIND_MAP, ATTR_IDLE_CODE, 1'b0, 8'd7, 24'h0, 24'h0, 24'h0));
        send_item(make_item(KIND_IDLE_CODE, ATTR_POS, 1'b0, 8'd0, 24'h5, 24'h5, 24'h5));
        send_item(make_item(KIND_CLEAR, ATTR_UV, 1'b1, 8'd3, 24'h0, 24'h0, 24'h0));
        // The remap store survives a clear.
        send_item(make_item(KIND_MAP, ATTR_UV, 1'b1, 8'd170, 24'h0, 24'h0, 24'h0));
        send_item(make_item(KIND_ADD, ATTR_POS, 1'b0, 8'd2, 24'h800000, 24'h800000, 24'h800000));
        send_item(make_item(KIND_MAP, ATTR_POS, 1'b0, 8'd2, 24'h0, 24'h0, 24'h0));
        write_threshold(THRESH_MAX);
        send_item(make_item(KIND_ADD, ATTR_POS, 1'b1, 8'd9, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        write_threshold(ThreshBits'(3));
        send_item(make_item(KIND_ADD, ATTR_POS, 1'b1, 8'd10, 24'h800001, 24'h800001, 24'h800001));
        send_item(make_item(KIND_ADD, ATTR_POS, 1'b1, 8'd11, 24'h800002, 24'h800001, 24'h800001));
        send_item(make_item(KIND_CLEAR, ATTR_POS, 1'b0, 8'd0, 24'h0, 24'h0, 24'h0));
    endtask

    // The receiver holds off while items keep coming, so the queue fills up.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        wait_idle();
        hold_left = 400;
        for (int i = 0; i < 12; i++)
            send_item(make_item(i % 3 == 1 ? KIND_MAP : KIND_ADD, ATTR_NRM, 1'b0, 8'd128,
                                24'($urandom), 24'($urandom), 24'($urandom)));
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct,
                               logic [ThreshBits-1:0] threshold);
        in_item_t it;
        int pick;
        int key;
        logic [1:0] attr;
        write_threshold(threshold);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            attr = 2'($urandom_range(2));
            it = make_item(KIND_ADD, attr, 1'($urandom), 8'($urandom),
                           24'($urandom), 24'($urandom), 24'($urandom));
            if (pick < 7) begin
                it.kind = KIND_CLEAR;
            end else if (pick < 10) begin
                if (pick[0]) it.kind = KIND_IDLE_CODE;
                else it.attribute = ATTR_IDLE_CODE;
            end else if (pick < 35 && slot_keys.size() != 0) begin
                key = slot_keys[$urandom_range(slot_keys.size() - 1)];
                it.kind = KIND_MAP;
                {it.cluster, it.attribute, it.local_index} = 11'(key);
            end else if (pick < 70 && weld_count[attr] != 0) begin
                // Near copy of a stored vector, so that welds occur.
                key = $urandom_range(weld_count[attr] - 1);
                it.comp_a = weld_vec[attr][key][0] + 24'($urandom_range(4)) - 24'd2;
                it.comp_b = weld_vec[attr][key][1] + 24'($urandom_range(4)) - 24'd2;
                it.comp_c = weld_vec[attr][key][2] + 24'($urandom_range(4)) - 24'd2;
            end
            send_item(it);
        end
    endtask

    initial begin
        failed = 1'b0;
        hold_left = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        weld_threshold = '0;
        weld_count = '{0, 0, 0};
        slot_written = '{default: 1'b0};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(140, 0, 0, ThreshBits'(0));
        test_random(130, 79, 0, ThreshBits'(12));
        test_random(130, 0, 79, THRESH_MAX);
        test_random(130, 19, 19, ThreshBits'(1) << 33);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
